/* hw/rtl/ighd_pkg.sv */
// Shared constants, codes and types of the interval graph hop distance block.
package ighd_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int JUMP_LEVELS_DEF = 11;

    localparam int VALUE_W   = 31;
    localparam int ID_W      = 10;
    localparam int COUNT_W   = 11;
    localparam int HOP_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF   = 2'd1;

    localparam logic [HOP_W-1:0] HOP_NONE = 11'h7FF;
    localparam logic [HOP_W-1:0] HOP_SAT  = 11'd1023;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ID_W-1:0]    node_id;
        logic [VALUE_W-1:0] node_value;
        logic [ID_W-1:0]    other_node;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
        logic [VALUE_W-1:0] max_diff;
    } cfg_t;

endpackage

/* hw/rtl/ighd_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module ighd_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ighd_ctrl.sv */
// Sequencer for build and query, with the node memories and the shared limit comparator.
module ighd_ctrl #(
    parameter int MAX_NODES   = ighd_pkg::MAX_NODES_DEF,
    parameter int JUMP_LEVELS = ighd_pkg::JUMP_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  ighd_pkg::item_t               item,
    input  ighd_pkg::cfg_t                cfg,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_take,
    output logic [ighd_pkg::HOP_W-1:0]    res_value
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int LW  = $clog2(JUMP_LEVELS);
    localparam int SW  = JUMP_LEVELS + 1;
    localparam int JD  = JUMP_LEVELS * MAX_NODES;
    localparam int JAW = $clog2(JD);
    localparam int VW  = ighd_pkg::VALUE_W;

    typedef enum logic [4:0] {
        S_IDLE, S_R_RDI, S_R_GETI, S_R_RDK, S_R_CMPK, S_R_WR,
        S_F_RDI, S_F_GETI, S_F_CHK, S_F_CMP, S_F_WR,
        S_L_RDA, S_L_GETA, S_L_RDB, S_L_GETB,
        S_Q_RDU, S_Q_GETU, S_Q_GETV, S_Q_RDS, S_Q_GETSU, S_Q_GETSV,
        S_J_RD, S_J_GET, S_J_CMP, S_E_RD, S_E_GET, S_E_CMP, S_RESULT
    } state_t;

    state_t state_reg;

    logic [CW-1:0]        n_reg, i_reg, k_reg, cnt_reg, bc_reg;
    logic [VW-1:0]        md_reg, bd_reg, lo_reg, sv_reg;
    logic [NW-1:0]        far_reg, a_reg, u_reg, v_reg, t_reg;
    logic [LW-1:0]        lvl_reg;
    logic [SW-1:0]        steps_reg;
    logic [ighd_pkg::ID_W-1:0] qa_reg, qb_reg;
    logic [ighd_pkg::HOP_W-1:0] res_reg;

    logic          raw_we, rank_we, sort_we, jump_we;
    logic [NW-1:0] raw_waddr, raw_raddr, rank_waddr, rank_raddr, sort_waddr, sort_raddr;
    logic [VW-1:0] raw_rd, sort_rd;
    logic [NW-1:0] rank_rd, jump_rd, jump_wdata;
    logic [JAW-1:0] jump_waddr, jump_raddr;

    logic [NW-1:0] i_idx;
    logic [LW-1:0] lvl_dn;
    logic          i_last, lvl_top, lvl_zero;
    logic          rank_less;
    logic [VW-1:0] cmp_hi, cmp_lo, cmp_md;
    logic          fits;
    logic [31:0]   n_eff, steps_p2;

    function automatic logic [JAW-1:0] jaddr(input logic [LW-1:0] lvl, input logic [NW-1:0] pos);
        jaddr = JAW'(lvl) * JAW'(MAX_NODES) + JAW'(pos);
    endfunction

    assign i_idx    = i_reg[NW-1:0];
    assign lvl_dn   = lvl_reg - 1'b1;
    assign i_last   = (i_reg + 1'b1) == n_reg;
    assign lvl_top  = lvl_reg == LW'(JUMP_LEVELS - 1);
    assign lvl_zero = lvl_reg == '0;

    // Sort key is the value, then the node id, so equal values are ordered by node id.
    assign rank_less = (raw_rd < lo_reg) || ((raw_rd == lo_reg) && (k_reg < i_reg));

    // The one limit comparator: hi <= lo + limit, formed one bit wider.
    always_comb
    begin
        if (state_reg == S_F_CMP || state_reg == S_Q_GETSV)
        begin
            cmp_hi = sort_rd;
            cmp_lo = lo_reg;
        end
        else
        begin
            cmp_hi = sv_reg;
            cmp_lo = sort_rd;
        end
        cmp_md = (state_reg == S_F_CMP) ? md_reg : bd_reg;
    end
    assign fits = {1'b0, cmp_hi} <= ({1'b0, cmp_lo} + {1'b0, cmp_md});

    always_comb
    begin
        n_eff = 32'(cfg.node_count);
        if (n_eff == 32'd0)
        begin
            n_eff = 32'd1;
        end
        else if (n_eff > 32'(MAX_NODES))
        begin
            n_eff = 32'(MAX_NODES);
        end
    end

    assign steps_p2 = 32'(steps_reg) + 32'd2;

    always_comb
    begin
        raw_we     = (state_reg == S_IDLE) && item_valid &&
                     (item.operation == ighd_pkg::OP_LOAD) &&
                     (32'(item.node_id) < 32'(MAX_NODES));
        raw_waddr  = NW'(item.node_id);
        raw_raddr  = (state_reg == S_R_RDI) ? i_idx : k_reg[NW-1:0];

        rank_we    = state_reg == S_R_WR;
        rank_waddr = i_idx;
        rank_raddr = (state_reg == S_Q_GETU) ? NW'(qb_reg) : NW'(qa_reg);

        sort_we    = state_reg == S_R_WR;
        sort_waddr = cnt_reg[NW-1:0];
        case (state_reg)
            S_F_CHK:   sort_raddr = NW'(CW'(far_reg) + 1'b1);
            S_Q_RDS:   sort_raddr = u_reg;
            S_Q_GETSU: sort_raddr = v_reg;
            S_J_GET:   sort_raddr = jump_rd;
            S_E_GET:   sort_raddr = jump_rd;
            default:   sort_raddr = i_idx;
        endcase

        case (state_reg)
            S_L_RDB: jump_raddr = jaddr(lvl_dn, a_reg);
            S_J_RD:  jump_raddr = jaddr(lvl_reg, u_reg);
            S_E_RD:  jump_raddr = jaddr('0, u_reg);
            default: jump_raddr = jaddr(lvl_dn, i_idx);
        endcase
        jump_we    = 1'b0;
        jump_waddr = jaddr(lvl_reg, i_idx);
        jump_wdata = i_idx;
        case (state_reg)
            S_F_WR:
            begin
                jump_we    = 1'b1;
                jump_waddr = jaddr('0, i_idx);
                jump_wdata = far_reg;
            end
            S_L_GETA:
            begin
                jump_we = jump_rd == i_idx;
            end
            S_L_GETB:
            begin
                jump_we    = 1'b1;
                jump_wdata = (jump_rd == a_reg) ? i_idx : jump_rd;
            end
            default:
            begin
                jump_we = 1'b0;
            end
        endcase
    end

    ighd_ram #(.DW(VW), .DEPTH(MAX_NODES)) u_raw (
        .clk(clk), .we(raw_we), .waddr(raw_waddr), .wdata(item.node_value),
        .raddr(raw_raddr), .rdata(raw_rd)
    );

    ighd_ram #(.DW(NW), .DEPTH(MAX_NODES)) u_rank (
        .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(cnt_reg[NW-1:0]),
        .raddr(rank_raddr), .rdata(rank_rd)
    );

    ighd_ram #(.DW(VW), .DEPTH(MAX_NODES)) u_sorted (
        .clk(clk), .we(sort_we), .waddr(sort_waddr), .wdata(lo_reg),
        .raddr(sort_raddr), .rdata(sort_rd)
    );

    ighd_ram #(.DW(NW), .DEPTH(JD)) u_jump (
        .clk(clk), .we(jump_we), .waddr(jump_waddr), .wdata(jump_wdata),
        .raddr(jump_raddr), .rdata(jump_rd)
    );

    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_RESULT;
    assign res_value = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bc_reg    <= '0;
            bd_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid && item.operation == ighd_pkg::OP_BUILD)
                    begin
                        n_reg     <= CW'(n_eff);
                        md_reg    <= cfg.max_diff;
                        i_reg     <= '0;
                        state_reg <= S_R_RDI;
                    end
                    else if (item_valid && item.operation == ighd_pkg::OP_QUERY)
                    begin
                        qa_reg <= item.node_id;
                        qb_reg <= item.other_node;
                        if (32'(item.node_id) >= 32'(bc_reg) ||
                            32'(item.other_node) >= 32'(bc_reg))
                        begin
                            res_reg   <= ighd_pkg::HOP_NONE;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_Q_RDU;
                        end
                    end
                end
                S_R_RDI:
                begin
                    k_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_R_GETI;
                end
                S_R_GETI:
                begin
                    lo_reg    <= raw_rd;
                    state_reg <= S_R_RDK;
                end
                S_R_RDK:
                begin
                    state_reg <= S_R_CMPK;
                end
                S_R_CMPK:
                begin
                    if (rank_less)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= ((k_reg + 1'b1) == n_reg) ? S_R_WR : S_R_RDK;
                end
                S_R_WR:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        far_reg   <= '0;
                        state_reg <= S_F_RDI;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_R_RDI;
                    end
                end
                S_F_RDI:
                begin
                    if (far_reg < i_idx)
                    begin
                        far_reg <= i_idx;
                    end
                    state_reg <= S_F_GETI;
                end
                S_F_GETI:
                begin
                    lo_reg    <= sort_rd;
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    state_reg <= ((CW'(far_reg) + 1'b1) < n_reg) ? S_F_CMP : S_F_WR;
                end
                S_F_CMP:
                begin
                    if (fits)
                    begin
                        far_reg   <= far_reg + 1'b1;
                        state_reg <= S_F_CHK;
                    end
                    else
                    begin
                        state_reg <= S_F_WR;
                    end
                end
                S_F_WR:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        lvl_reg   <= LW'(1);
                        state_reg <= S_L_RDA;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_F_RDI;
                    end
                end
                S_L_RDA:
                begin
                    state_reg <= S_L_GETA;
                end
                S_L_GETA, S_L_GETB:
                begin
                    a_reg <= jump_rd;
                    if (state_reg == S_L_GETA && jump_rd != i_idx)
                    begin
                        state_reg <= S_L_RDB;
                    end
                    else if (i_last)
                    begin
                        i_reg <= '0;
                        if (lvl_top)
                        begin
                            bc_reg    <= n_reg;
                            bd_reg    <= md_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            lvl_reg   <= lvl_reg + 1'b1;
                            state_reg <= S_L_RDA;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_L_RDA;
                    end
                end
                S_L_RDB:
                begin
                    state_reg <= S_L_GETB;
                end
                S_Q_RDU:
                begin
                    state_reg <= S_Q_GETU;
                end
                S_Q_GETU:
                begin
                    u_reg     <= rank_rd;
                    state_reg <= S_Q_GETV;
                end
                S_Q_GETV:
                begin
                    if (rank_rd == u_reg)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        if (rank_rd < u_reg)
                        begin
                            u_reg <= rank_rd;
                            v_reg <= u_reg;
                        end
                        else
                        begin
                            v_reg <= rank_rd;
                        end
                        state_reg <= S_Q_RDS;
                    end
                end
                S_Q_RDS:
                begin
                    state_reg <= S_Q_GETSU;
                end
                S_Q_GETSU:
                begin
                    lo_reg    <= sort_rd;
                    state_reg <= S_Q_GETSV;
                end
                S_Q_GETSV:
                begin
                    sv_reg    <= sort_rd;
                    steps_reg <= '0;
                    lvl_reg   <= LW'(JUMP_LEVELS - 1);
                    if (fits)
                    begin
                        res_reg   <= ighd_pkg::HOP_W'(1);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_J_RD;
                    end
                end
                S_J_RD:
                begin
                    state_reg <= S_J_GET;
                end
                S_J_GET, S_J_CMP:
                begin
                    t_reg <= jump_rd;
                    if (state_reg == S_J_GET && jump_rd != u_reg)
                    begin
                        state_reg <= S_J_CMP;
                    end
                    else
                    begin
                        // A jump is taken only while it still stops short of the target.
                        if (state_reg == S_J_CMP && !fits)
                        begin
                            u_reg     <= t_reg;
                            steps_reg <= steps_reg + (SW'(1) << lvl_reg);
                        end
                        if (lvl_zero)
                        begin
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            lvl_reg   <= lvl_dn;
                            state_reg <= S_J_RD;
                        end
                    end
                end
                S_E_RD:
                begin
                    state_reg <= S_E_GET;
                end
                S_E_GET:
                begin
                    if (jump_rd == u_reg)
                    begin
                        res_reg   <= ighd_pkg::HOP_NONE;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_E_CMP;
                    end
                end
                S_E_CMP:
                begin
                    if (!fits)
                    begin
                        res_reg <= ighd_pkg::HOP_NONE;
                    end
                    else if (steps_p2 > 32'(ighd_pkg::HOP_SAT))
                    begin
                        res_reg <= ighd_pkg::HOP_SAT;
                    end
                    else
                    begin
                        res_reg <= steps_p2[ighd_pkg::HOP_W-1:0];
                    end
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/interval_graph_hop_distance.sv */
// Top level: configuration registers, item port and result output register.
//
//   channel  | direction | handshake            | payload
//   item     | in        | in_valid / in_stall   | operation, node_id, node_value, other_node
//   result   | out       | out_valid / out_stall | hop_count
//   config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A load does not stall the input. A build stalls it longest in the rank count, which
// reads the value memory once for every node pair. A query stalls the input when a node
// is out of range, for the same node, when the two are adjacent, and longest when it
// walks the levels, one jump table and one value read per level.
// Reset clears control state and the latched build; memories hold garbage until written.
// A result waits in the output register under out_stall while the next item is taken.
module interval_graph_hop_distance #(
    parameter int MAX_NODES   = ighd_pkg::MAX_NODES_DEF,
    parameter int JUMP_LEVELS = ighd_pkg::JUMP_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [ighd_pkg::ID_W-1:0]         node_id,
    input  logic [ighd_pkg::VALUE_W-1:0]      node_value,
    input  logic [ighd_pkg::ID_W-1:0]         other_node,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ighd_pkg::HOP_W-1:0] hop_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ighd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ighd_pkg::VALUE_W-1:0]      cfg_data
);

    ighd_pkg::cfg_t  cfg_reg;
    ighd_pkg::item_t item;
    logic            ctrl_idle, res_valid, res_take, item_valid;
    logic [ighd_pkg::HOP_W-1:0] res_value;
    logic            out_valid_reg;
    logic [ighd_pkg::HOP_W-1:0] hop_reg;

    assign cfg_ready  = 1'b1;
    assign in_stall   = !ctrl_idle;
    assign item_valid = in_valid && !in_stall;
    assign item       = '{operation: operation, node_id: node_id,
                          node_value: node_value, other_node: other_node};
    assign res_take   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign hop_count  = hop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count <= ighd_pkg::COUNT_W'(1);
            cfg_reg.max_diff   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ighd_pkg::CFG_NODE_COUNT: cfg_reg.node_count <= cfg_data[ighd_pkg::COUNT_W-1:0];
                ighd_pkg::CFG_MAX_DIFF:   cfg_reg.max_diff   <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                hop_reg <= res_value;
            end
        end
    end

    ighd_ctrl #(.MAX_NODES(MAX_NODES), .JUMP_LEVELS(JUMP_LEVELS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item(item), .cfg(cfg_reg),
        .idle(ctrl_idle), .res_valid(res_valid), .res_take(res_take), .res_value(res_value)
    );

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && operation == ighd_pkg::OP_QUERY) |=> in_stall)
        else $error("query transfer did not make the block busy");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && operation == ighd_pkg::OP_LOAD) |=> !res_valid)
        else $error("load produced a result");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(res_valid))
        else $error("output valid rose without a finished result");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the interval graph hop distance block.
module tb_top;

    localparam int NODES     = ighd_pkg::MAX_NODES_DEF;
    localparam int LEVELS    = ighd_pkg::JUMP_LEVELS_DEF;
    localparam int ID_W      = ighd_pkg::ID_W;
    localparam int VALUE_W   = ighd_pkg::VALUE_W;
    localparam int HOP_W     = ighd_pkg::HOP_W;
    localparam int COUNT_W   = ighd_pkg::COUNT_W;
    localparam int CFG_IDX_W = ighd_pkg::CFG_IDX_W;
    localparam int STALL_MAX = 10;
    localparam int WATCHDOG  = 8000000;

    // Operation code with no function; the block must ignore it.
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               operation;
    logic [ID_W-1:0]          node_id;
    logic [VALUE_W-1:0]       node_value;
    logic [ID_W-1:0]          other_node;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [HOP_W-1:0]  hop_count;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [VALUE_W-1:0]       cfg_data;

    interval_graph_hop_distance i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .node_id    (node_id),
        .node_value (node_value),
        .other_node (other_node),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hop_count  (hop_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Predictor state.
    logic [VALUE_W-1:0] node_vals [NODES];
    bit                 loaded    [NODES];
    logic [VALUE_W-1:0] ranked_vals [NODES];
    int                 rank_of   [NODES];
    int                 jumps     [NODES][LEVELS];
    logic [COUNT_W-1:0] count_reg;
    logic [VALUE_W-1:0] diff_reg;
    int                 built_n;
    longint             built_diff;

    logic [HOP_W-1:0]   expected_hops [$];
    int                 mismatches;
    bit                 fast_mode;
    int                 hold_request;
    int                 hold_left;
    int                 stall_left;
    int                 quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int active_count();
        if (count_reg == 0)
            return 1;
        if (count_reg > NODES)
            return NODES;
        return int'(count_reg);
    endfunction

    // Stable sort by value, greedy reach per position, then doubling levels.
    function automatic void build_jumps();
        int n;
        int order [NODES];
        int k;
        int far;
        int a;
        int b;
        n = active_count();
        for (int i = 0; i < n; i++)
        begin
            k = i;
            while (k > 0 && node_vals[order[k-1]] > node_vals[i])
            begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        for (int i = 0; i < n; i++)
        begin
            ranked_vals[i] = node_vals[order[i]];
            rank_of[order[i]] = i;
        end
        far = 0;
        for (int i = 0; i < n; i++)
        begin
            if (far < i)
                far = i;
            while (far + 1 < n && longint'(ranked_vals[far+1]) <=
                   longint'(ranked_vals[i]) + longint'(diff_reg))
                far++;
            jumps[i][0] = far;
        end
        for (int j = 1; j < LEVELS; j++)
        begin
            for (int i = 0; i < n; i++)
            begin
                a = jumps[i][j-1];
                b = (a == i) ? i : jumps[a][j-1];
                jumps[i][j] = (a == i || b == a) ? i : b;
            end
        end
        built_n = n;
        built_diff = longint'(diff_reg);
    endfunction

    function automatic logic [HOP_W-1:0] min_hops(int a, int b);
        int u;
        int v;
        int t;
        int steps;
        if (a >= built_n || b >= built_n)
            return ighd_pkg::HOP_NONE;
        u = rank_of[a];
        v = rank_of[b];
        if (u == v)
            return '0;
        if (u > v)
        begin
            t = u;
            u = v;
            v = t;
        end
        if (longint'(ranked_vals[v]) <= longint'(ranked_vals[u]) + built_diff)
            return 1;
        steps = 0;
        for (int j = LEVELS - 1; j >= 0; j--)
        begin
            t = jumps[u][j];
            if (t != u && longint'(ranked_vals[v]) > longint'(ranked_vals[t]) + built_diff)
            begin
                u = t;
                steps += 1 << j;
            end
        end
        t = jumps[u][0];
        if (t != u && longint'(ranked_vals[v]) <= longint'(ranked_vals[t]) + built_diff)
        begin
            steps += 2;
            return (steps > ighd_pkg::HOP_SAT) ? ighd_pkg::HOP_SAT : HOP_W'(steps);
        end
        return ighd_pkg::HOP_NONE;
    endfunction

    function automatic int draw_wait();
        if (fast_mode)
            return 0;
        return $urandom_range(0, STALL_MAX);
    endfunction

    // Offers one item and returns in the cycle of its transfer; valid stays high.
    task automatic send_item(logic [1:0] op, int id, logic [VALUE_W-1:0] val, int other);
        int gap;
        logic [ID_W-1:0] id_bits;
        logic [ID_W-1:0] other_bits;
        gap = draw_wait();
        id_bits = ID_W'(id);
        other_bits = ID_W'(other);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        node_id    <= id_bits;
        node_value <= val;
        other_node <= other_bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op)
            ighd_pkg::OP_LOAD:
            begin
                node_vals[id_bits] = val;
                loaded[id_bits] = 1'b1;
            end
            ighd_pkg::OP_BUILD:
            begin
                build_jumps();
            end
            ighd_pkg::OP_QUERY:
                expected_hops = {expected_hops, min_hops(int'(id_bits), int'(other_bits))};
            default:
                ;
        endcase
    endtask

    // Drops valid and waits until every result is in and the block is idle again.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_hops.size() != 0 || in_stall)
            @(posedge clk);
        repeat (4 * LEVELS + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ighd_pkg::CFG_NODE_COUNT)
            count_reg = data[COUNT_W-1:0];
        else if (idx == ighd_pkg::CFG_MAX_DIFF)
            diff_reg = data;
    endtask

    // Loads every node of the active set that still lacks a value, then builds.
    task automatic load_and_build(int value_range);
        for (int i = 0; i < active_count(); i++)
            if (!loaded[i])
                send_item(ighd_pkg::OP_LOAD, i, VALUE_W'($urandom_range(0, value_range)), 0);
        send_item(ighd_pkg::OP_BUILD, $urandom_range(0, NODES - 1), VALUE_W'($urandom),
                  $urandom);
    endtask

    task automatic test_after_reset();
        send_item(ighd_pkg::OP_QUERY, 0, '0, 0);
        send_item(OP_SPARE, NODES - 1, '1, NODES - 1);
        send_item(ighd_pkg::OP_LOAD, 0, '1, 0);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 0, '0, 1);
        send_item(ighd_pkg::OP_QUERY, NODES - 1, '0, 0);
    endtask

    task automatic test_directed();
        write_reg(ighd_pkg::CFG_NODE_COUNT, 8);
        write_reg(ighd_pkg::CFG_MAX_DIFF, 10);
        // A chain 0-10-20-30, a tie at 30, and two far-off nodes at the top.
        send_item(ighd_pkg::OP_LOAD, 1, 0, 0);
        send_item(ighd_pkg::OP_LOAD, 2, 10, 0);
        send_item(ighd_pkg::OP_LOAD, 3, 20, 0);
        send_item(ighd_pkg::OP_LOAD, 4, 30, 0);
        send_item(ighd_pkg::OP_LOAD, 5, 30, 0);
        send_item(ighd_pkg::OP_LOAD, 6, '1, 0);
        send_item(ighd_pkg::OP_LOAD, 7, VALUE_W'(32'h7FFF_FFF0), 0);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 1, '0, 4);
        send_item(ighd_pkg::OP_QUERY, 4, '0, 1);
        send_item(ighd_pkg::OP_QUERY, 4, '0, 5);
        send_item(ighd_pkg::OP_QUERY, 1, '0, 2);
        send_item(ighd_pkg::OP_QUERY, 0, '0, 6);
        send_item(ighd_pkg::OP_QUERY, 6, '0, 7);
        send_item(ighd_pkg::OP_QUERY, 2, '0, 8);
        // The latched limit stays in force until the next build.
        write_reg(ighd_pkg::CFG_MAX_DIFF, '1);
        send_item(ighd_pkg::OP_QUERY, 1, '0, 6);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 1, '0, 6);
        send_item(ighd_pkg::OP_QUERY, 6, '0, 7);
        write_reg(ighd_pkg::CFG_MAX_DIFF, 0);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 4, '0, 5);
        send_item(ighd_pkg::OP_QUERY, 5, '0, 5);
        write_reg(ighd_pkg::CFG_NODE_COUNT, 0);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 0, '0, 1);
    endtask

    task automatic test_random_sets();
        int n;
        int span;
        int pick;
        for (int phase = 0; phase < 20; phase++)
        begin
            fast_mode = (phase % 5 == 4);
            n = (phase % 7 == 6) ? $urandom_range(33, 96) : $urandom_range(2, 24);
            write_reg(ighd_pkg::CFG_NODE_COUNT, VALUE_W'(n));
            case (phase % 3)
                0: write_reg(ighd_pkg::CFG_MAX_DIFF, VALUE_W'($urandom_range(0, 4)));
                1: write_reg(ighd_pkg::CFG_MAX_DIFF, VALUE_W'($urandom_range(0, 40)));
                default: write_reg(ighd_pkg::CFG_MAX_DIFF, VALUE_W'($urandom));
            endcase
            span = (phase % 3 == 2) ? 32'h7FFF_FFFF : n * 8;
            for (int i = 0; i < n; i++)
                send_item(ighd_pkg::OP_LOAD, i, VALUE_W'($urandom_range(0, span)), $urandom);
            send_item(ighd_pkg::OP_BUILD, $urandom, VALUE_W'($urandom), $urandom);
            for (int k = 0; k < 15; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    send_item(ighd_pkg::OP_QUERY, $urandom_range(0, n - 1), VALUE_W'($urandom),
                              $urandom_range(0, n - 1));
                else if (pick < 17)
                    send_item(ighd_pkg::OP_QUERY, $urandom, VALUE_W'($urandom), $urandom);
                else if (pick < 18)
                    send_item(OP_SPARE, $urandom, VALUE_W'($urandom), $urandom);
                else
                    send_item(ighd_pkg::OP_LOAD, $urandom_range(0, n - 1),
                              VALUE_W'($urandom_range(0, span)), $urandom);
            end
        end
        fast_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(ighd_pkg::CFG_NODE_COUNT, 16);
        write_reg(ighd_pkg::CFG_MAX_DIFF, 3);
        load_and_build(64);
        fast_mode = 1'b1;
        hold_request = 3000;
        for (int k = 0; k < 40; k++)
            send_item(ighd_pkg::OP_QUERY, $urandom_range(0, 15), '0, $urandom_range(0, 15));
        fast_mode = 1'b0;
        // Sender pauses until the block has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_hops.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 20; k++)
            send_item(ighd_pkg::OP_QUERY, $urandom_range(0, 15), '0, $urandom_range(0, 15));
    endtask

    task automatic test_full_set();
        write_reg(ighd_pkg::CFG_NODE_COUNT, 11'h7FF);
        write_reg(ighd_pkg::CFG_MAX_DIFF, 1);
        fast_mode = 1'b1;
        // One long chain, so the end to end distance is the largest one possible.
        for (int i = NODES - 1; i >= 0; i--)
            send_item(ighd_pkg::OP_LOAD, i, VALUE_W'(i), 0);
        send_item(ighd_pkg::OP_BUILD, 0, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 0, '0, NODES - 1);
        send_item(ighd_pkg::OP_QUERY, NODES - 1, '0, 0);
        send_item(ighd_pkg::OP_QUERY, 3, '0, 700);
        send_item(ighd_pkg::OP_QUERY, 512, '0, 513);
        fast_mode = 1'b0;
        for (int k = 0; k < 20; k++)
            send_item(ighd_pkg::OP_QUERY, $urandom, '0, $urandom);
    endtask

    // Receiver: draws stalls per result and honors long hold-off requests.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_hops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: hop_count %0d", hop_count);
            end
            else
            begin
                if (hop_count !== expected_hops[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hop_count mismatch: expected %0d got %0d",
                                 $signed(expected_hops[0]), hop_count);
                end
                void'(expected_hops.pop_front());
            end
            stall_left = draw_wait();
        end
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= ighd_pkg::OP_LOAD;
        node_id    <= '0;
        node_value <= '0;
        other_node <= '0;
        out_stall  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= ighd_pkg::CFG_NODE_COUNT;
        cfg_data   <= '0;
        count_reg = 1;
        diff_reg = '0;
        built_n = 0;
        built_diff = 0;
        mismatches = 0;
        fast_mode = 1'b0;
        hold_request = 0;
        hold_left = 0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed();
        test_random_sets();
        test_backpressure();
        test_full_set();

        settle();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_hops.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* interval_graph_hop_distance.f */
hw/rtl/ighd_pkg.sv
hw/rtl/ighd_ram.sv
hw/rtl/ighd_ctrl.sv
hw/rtl/interval_graph_hop_distance.sv
tb/tb_top.sv
